FILE: hdl/erc_pkg.sv
// Shared types, constants and lookup functions of the three-rotor cipher core.
// Holds the rotor and reflector wirings, notch table and modulo-26 helpers.
// No dependencies; every other file in hdl imports this package.
`default_nettype none

package erc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 45;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROTOR_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLUG_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLUG_MID    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLUG_HIGH   = 3'd4;

    // item kinds carried on tuser
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_ENCIPHER = 1'b1;

    localparam logic [8:0]  ROTOR_ORDER_RST = 9'd83;
    localparam logic [14:0] RING_RST        = 15'd0;
    localparam logic [44:0] PLUG_LOW_RST    = 45'd9043225708576;
    localparam logic [44:0] PLUG_MID_RST    = 45'd19258043411785;
    localparam logic [39:0] PLUG_HIGH_RST   = 40'd885558792818;

    typedef logic [4:0] letter_t;

    typedef struct packed {
        logic [8:0]  rotor_order;
        logic [14:0] ring_settings;
        logic [44:0] plug_low;
        logic [44:0] plug_mid;
        logic [39:0] plug_high;
    } cfg_t;

    // one accepted item after rotor stepping
    typedef struct packed {
        logic    op;
        letter_t letter;
        letter_t left;
        letter_t middle;
        letter_t right;
    } item_t;

    // one item inside the substitution pipeline
    typedef struct packed {
        logic    op;
        letter_t x;
        letter_t off_l;
        letter_t off_m;
        letter_t off_r;
        letter_t left;
        letter_t middle;
        letter_t right;
    } stage_t;

    // 26 ASCII characters, letter A in the top byte
    typedef logic [207:0] wiring_t;

    localparam wiring_t FWD_WIRING [8] = '{
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "VZBRGITYUPSDNHLXAWMJQOFECK",
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ"
    };

    localparam wiring_t INV_WIRING [8] = '{
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
        "UWYGADFPVZBECKMTHXSLRINQOJ",
        "AJPCZWRLFBDKOTYUQGENHXMIVS",
        "TAGBPCSDQEUFVNZHYIXJWLRKOM",
        "HZWVARTNLGUPXQCEJMBSKDYOIF",
        "QCYLXWENFTZOSMVJUDKGIARPHB",
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ"
    };

    localparam wiring_t REFLECTOR_B = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

    localparam letter_t NOTCH_POS [8] = '{
        5'd0, 5'd16, 5'd4, 5'd21, 5'd9, 5'd25, 5'd0, 5'd0
    };
    // bit per rotor code: rotors I..V have a notch
    localparam logic [7:0] NOTCH_OK = 8'b0011_1110;

    function automatic letter_t sat25(input logic [4:0] v);
        return (v > 5'd25) ? 5'd25 : v;
    endfunction

    function automatic letter_t inc_mod26(input letter_t p);
        return (p == 5'd25) ? 5'd0 : p + 5'd1;
    endfunction

    function automatic letter_t add_mod26(input letter_t a, input letter_t b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 6'd26)
            s = s - 6'd26;
        return s[4:0];
    endfunction

    function automatic letter_t sub_mod26(input letter_t a, input letter_t b);
        logic [5:0] s;
        s = {1'b0, a} + 6'd26 - {1'b0, b};
        if (s >= 6'd26)
            s = s - 6'd26;
        return s[4:0];
    endfunction

    function automatic letter_t wire_lookup(input wiring_t w, input letter_t x);
        logic [4:0] idx;
        logic [7:0] ch;
        idx = 5'd25 - x;
        ch  = w[{idx, 3'b000} +: 8];
        ch  = ch - 8'd65;
        return ch[4:0];
    endfunction

    function automatic letter_t fwd_pass(input logic [2:0] code, input letter_t off,
                                         input letter_t x);
        letter_t t;
        t = add_mod26(x, off);
        t = wire_lookup(FWD_WIRING[code], t);
        return sub_mod26(t, off);
    endfunction

    function automatic letter_t inv_pass(input logic [2:0] code, input letter_t off,
                                         input letter_t x);
        letter_t t;
        t = add_mod26(x, off);
        t = wire_lookup(INV_WIRING[code], t);
        return sub_mod26(t, off);
    endfunction

    function automatic logic notch_at(input logic [2:0] code, input letter_t pos);
        return NOTCH_OK[code] && (pos == NOTCH_POS[code]);
    endfunction

    function automatic letter_t plug(input cfg_t cfg, input letter_t k);
        logic [129:0] all_map;
        logic [7:0]   base;
        all_map = {cfg.plug_high, cfg.plug_mid, cfg.plug_low};
        base    = ({3'b000, k} << 2) + {3'b000, k};
        return sat25(all_map[base +: 5]);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/enigma_rotor_cipher_core.sv
// Top level of the three-rotor cipher core: configuration registers and the
// front end, queue and back end. Depends on erc_pkg, erc_front, erc_queue, erc_back.
//
//   channel   direction  transaction when          payload
//   s_*       in         s_tvalid && s_tready      tdata, tuser = op
//   m_*       out        m_tvalid && m_tready      tdata
//   cfg_*     in         cfg_we                    cfg_index, cfg_wdata
//
// One item per cycle sustained while the master side accepts; a result appears on m_tvalid
// once its item has passed the queue slot, three lookup stages and the output register.
// Rotor stepping is done at acceptance, so the position registers carry the
// only item-to-item dependency. Reset clears positions, queue and valid bits
// and restores the default configuration. A stalled master side fills the
// pipeline and then the queue before s_tready drops.
`default_nettype none

module enigma_rotor_cipher_core #(
    parameter int QUEUE_DEPTH = erc_pkg::QUEUE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [23:0]                     s_tdata,   // letter_in, start_left, start_middle, start_right
    input  wire logic                            s_tuser,   // op
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [23:0]                          m_tdata,   // letter_out, now_left, now_middle, now_right
    input  wire logic                            cfg_we,
    input  wire logic [erc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [erc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import erc_pkg::*;

    cfg_t  cfg_reg;
    logic  queue_full, push, pop, head_valid;
    item_t push_item, head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotor_order   <= ROTOR_ORDER_RST;
            cfg_reg.ring_settings <= RING_RST;
            cfg_reg.plug_low      <= PLUG_LOW_RST;
            cfg_reg.plug_mid      <= PLUG_MID_RST;
            cfg_reg.plug_high     <= PLUG_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROTOR_ORDER: cfg_reg.rotor_order   <= cfg_wdata[8:0];
                REG_RING:        cfg_reg.ring_settings <= cfg_wdata[14:0];
                REG_PLUG_LOW:    cfg_reg.plug_low      <= cfg_wdata[44:0];
                REG_PLUG_MID:    cfg_reg.plug_mid      <= cfg_wdata[44:0];
                REG_PLUG_HIGH:   cfg_reg.plug_high     <= cfg_wdata[39:0];
                default:         ;  // drop writes to unmapped indexes
            endcase
        end
    end

    erc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .rotor_order (cfg_reg.rotor_order),
        .queue_full  (queue_full),
        .push        (push),
        .push_item   (push_item)
    );

    erc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    erc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

FILE: hdl/erc_front.sv
// Front end: accepts stream items, loads or steps the rotor positions.
// Pushes each item with its resulting positions into the queue. Uses erc_pkg.
`default_nettype none

module erc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [23:0]    s_tdata,      // letter_in, start_left, start_middle, start_right
    input  wire logic           s_tuser,      // op
    input  wire logic [8:0]     rotor_order,
    input  wire logic           queue_full,
    output logic                push,
    output erc_pkg::item_t      push_item
);
    import erc_pkg::*;

    letter_t left_reg, middle_reg, right_reg;
    letter_t left_next, middle_next, right_next;
    logic    mid_notch, right_notch;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    assign mid_notch   = notch_at(rotor_order[5:3], middle_reg);
    assign right_notch = notch_at(rotor_order[2:0], right_reg);

    always_comb
    begin
        left_next   = left_reg;
        middle_next = middle_reg;
        right_next  = right_reg;
        if (push)
        begin
            if (s_tuser == OP_LOAD)
            begin
                left_next   = sat25(s_tdata[9:5]);
                middle_next = sat25(s_tdata[14:10]);
                right_next  = sat25(s_tdata[19:15]);
            end
            else
            begin
                // middle rotor double steps on its own notch
                if (mid_notch)
                    left_next = inc_mod26(left_reg);
                if (mid_notch || right_notch)
                    middle_next = inc_mod26(middle_reg);
                right_next = inc_mod26(right_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            middle_reg <= '0;
            right_reg  <= '0;
        end
        else
        begin
            left_reg   <= left_next;
            middle_reg <= middle_next;
            right_reg  <= right_next;
        end
    end

    assign push_item.op     = s_tuser;
    assign push_item.letter = s_tdata[4:0];
    assign push_item.left   = left_next;
    assign push_item.middle = middle_next;
    assign push_item.right  = right_next;

    a_right_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (push && s_tuser == OP_ENCIPHER) |=>
            (right_reg == (($past(right_reg) == 5'd25) ? 5'd0 : $past(right_reg) + 5'd1)))
        else $error("right rotor did not step on encipher item");

endmodule

`default_nettype wire

FILE: hdl/erc_queue.sv
// Short first-in first-out queue between the front end and the substitution back end.
// Register-file storage with read and write pointers. Uses erc_pkg for the item type.
`default_nettype none

module erc_queue #(
    parameter int DEPTH = erc_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire erc_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output erc_pkg::item_t      head_item
);
    import erc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty with pointers apart");

endmodule

`default_nettype wire

FILE: hdl/erc_back.sv
// Back end: three pipeline stages of plugboard, rotor, reflector lookups and an
// output register on the master stream. Uses erc_pkg for wirings and helpers.
`default_nettype none

module erc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire erc_pkg::cfg_t  cfg,
    input  wire logic           head_valid,
    input  wire erc_pkg::item_t head_item,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [23:0]         m_tdata       // letter_out, now_left, now_middle, now_right
);
    import erc_pkg::*;

    logic [2:0] code_l, code_m, code_r;
    letter_t    ring_l, ring_m, ring_r;

    stage_t  st1_reg, st1_next;
    stage_t  st2_reg, st2_next;
    stage_t  st3_reg, st3_next;
    logic    v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic    rdy1, rdy2, rdy3, out_rdy;
    letter_t x3, x4;
    logic [23:0] out_reg, out_next;

    assign code_l = cfg.rotor_order[8:6];
    assign code_m = cfg.rotor_order[5:3];
    assign code_r = cfg.rotor_order[2:0];
    assign ring_l = sat25(cfg.ring_settings[14:10]);
    assign ring_m = sat25(cfg.ring_settings[9:5]);
    assign ring_r = sat25(cfg.ring_settings[4:0]);

    // each stage moves when its successor has room
    assign out_rdy = !out_valid_reg || m_tready;
    assign rdy3    = !v3_reg || out_rdy;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign pop     = head_valid && rdy1;

    // stage 1: plugboard entry and rotor offsets
    always_comb
    begin
        st1_next.op     = head_item.op;
        st1_next.x      = plug(cfg, sat25(head_item.letter));
        st1_next.off_l  = sub_mod26(head_item.left, ring_l);
        st1_next.off_m  = sub_mod26(head_item.middle, ring_m);
        st1_next.off_r  = sub_mod26(head_item.right, ring_r);
        st1_next.left   = head_item.left;
        st1_next.middle = head_item.middle;
        st1_next.right  = head_item.right;
    end

    // stage 2: right and middle rotors, forward
    always_comb
    begin
        st2_next   = st1_reg;
        st2_next.x = fwd_pass(code_m, st1_reg.off_m,
                              fwd_pass(code_r, st1_reg.off_r, st1_reg.x));
    end

    // stage 3: left rotor, reflector, left rotor inverse
    always_comb
    begin
        x3 = fwd_pass(code_l, st2_reg.off_l, st2_reg.x);
        x3 = wire_lookup(REFLECTOR_B, x3);
        x3 = inv_pass(code_l, st2_reg.off_l, x3);
        st3_next   = st2_reg;
        st3_next.x = x3;
    end

    // last step: middle and right inverse, plugboard exit
    always_comb
    begin
        x4 = inv_pass(code_m, st3_reg.off_m, st3_reg.x);
        x4 = inv_pass(code_r, st3_reg.off_r, x4);
        x4 = plug(cfg, x4);
        if (st3_reg.op == OP_LOAD)
            x4 = '0;
        out_next = {4'b0000, st3_reg.right, st3_reg.middle, st3_reg.left, x4};
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
            st1_reg <= st1_next;
        if (rdy2)
            st2_reg <= st2_next;
        if (rdy3)
            st3_reg <= st3_next;
        if (out_rdy)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= head_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (out_rdy)
                out_valid_reg <= v3_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:0] <= 5'd25))
        else $error("enciphered letter out of range");

endmodule

`default_nettype wire

FILE: test/enigma_rotor_cipher_check.sv
// Scoreboard of the three-rotor cipher core: snoops the config port and both stream channels.
// It keeps its own rotor positions and keys, predicts each result and compares it.
// Depends on erc_pkg for register indexes, item kinds and reset values.
`default_nettype none

module enigma_rotor_cipher_check (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [23:0]                     s_tdata,   // letter_in, start_left, start_middle, start_right
    input  wire logic                            s_tuser,   // op
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [23:0]                     m_tdata,   // letter_out, now_left, now_middle, now_right
    input  wire logic                            cfg_we,
    input  wire logic [erc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [erc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                                   mismatches,
    output int                                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [8*26-1:0] alphabet_t;

    // highest field first, so letter lands in the low bits as on m_tdata
    typedef struct packed {
        logic [4:0] right;
        logic [4:0] middle;
        logic [4:0] left;
        logic [4:0] letter;
    } cipher_out_t;

    localparam alphabet_t PLAIN_ALPHA = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam alphabet_t REFLECT_B   = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

    logic [8:0]  key_rotors;
    logic [14:0] key_rings;
    logic [44:0] key_plug_low;
    logic [44:0] key_plug_mid;
    logic [39:0] key_plug_high;
    int          rot_left;
    int          rot_middle;
    int          rot_right;

    cipher_out_t cipher_expected [$];
    int          err_count = 0;
    int          pending_n = 0;

    assign mismatches  = err_count;
    assign outstanding = pending_n;

    function automatic int clamp25(input int v);
        return (v > 25) ? 25 : v;
    endfunction

    function automatic alphabet_t rotor_alpha(input int code, input bit reverse);
        case (code)
            1: return reverse ? "UWYGADFPVZBECKMTHXSLRINQOJ" : "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
            2: return reverse ? "AJPCZWRLFBDKOTYUQGENHXMIVS" : "AJDKSIRUXBLHWTMCQGZNPYFVOE";
            3: return reverse ? "TAGBPCSDQEUFVNZHYIXJWLRKOM" : "BDFHJLCPRTXVZNYEIWGAKMUSQO";
            4: return reverse ? "HZWVARTNLGUPXQCEJMBSKDYOIF" : "ESOVPZJAYQUIRHXLNFTGKDCMWB";
            5: return reverse ? "QCYLXWENFTZOSMVJUDKGIARPHB" : "VZBRGITYUPSDNHLXAWMJQOFECK";
            default: return PLAIN_ALPHA;
        endcase
    endfunction

    // letter A sits in the top byte of the string constant
    function automatic int alpha_at(input alphabet_t w, input int x);
        logic [7:0] ch;
        ch = w[8*(25-x) +: 8];
        return int'(ch) - 65;
    endfunction

    // -1 marks a rotor without a turnover notch
    function automatic int turnover(input int code);
        case (code)
            1: return 16;
            2: return 4;
            3: return 21;
            4: return 9;
            5: return 25;
            default: return -1;
        endcase
    endfunction

    function automatic int plug_target(input int k);
        logic [129:0] board;
        board = {key_plug_high, key_plug_mid, key_plug_low};
        return clamp25(int'(board[5*k +: 5]));
    endfunction

    function automatic int rotor_pass(input int code, input int offset, input int x,
                                      input bit reverse);
        int y;
        y = alpha_at(rotor_alpha(code, reverse), (x + offset) % 26);
        return (y + 26 - offset) % 26;
    endfunction

    task automatic step_and_encipher(input logic op, input logic [23:0] d,
                                     output cipher_out_t r);
        int code [3];
        int offs [3];
        int rings [3];
        int x;
        int i;
        bit mid_notch;
        bit right_notch;
        x = 0;
        if (op == erc_pkg::OP_LOAD) begin
            rot_left   = clamp25(int'(d[9:5]));
            rot_middle = clamp25(int'(d[14:10]));
            rot_right  = clamp25(int'(d[19:15]));
        end else begin
            code[0] = int'(key_rotors[8:6]);
            code[1] = int'(key_rotors[5:3]);
            code[2] = int'(key_rotors[2:0]);
            mid_notch   = (rot_middle == turnover(code[1]));
            right_notch = (rot_right == turnover(code[2]));
            // double step: middle rotor at its notch drags itself and the left one
            if (mid_notch)
                rot_left = (rot_left + 1) % 26;
            if (mid_notch || right_notch)
                rot_middle = (rot_middle + 1) % 26;
            rot_right = (rot_right + 1) % 26;

            rings[0] = clamp25(int'(key_rings[14:10]));
            rings[1] = clamp25(int'(key_rings[9:5]));
            rings[2] = clamp25(int'(key_rings[4:0]));
            offs[0] = (rot_left + 26 - rings[0]) % 26;
            offs[1] = (rot_middle + 26 - rings[1]) % 26;
            offs[2] = (rot_right + 26 - rings[2]) % 26;

            x = plug_target(clamp25(int'(d[4:0])));
            for (i = 2; i >= 0; i--)
                x = rotor_pass(code[i], offs[i], x, 1'b0);
            x = alpha_at(REFLECT_B, x);
            for (i = 0; i < 3; i++)
                x = rotor_pass(code[i], offs[i], x, 1'b1);
            x = plug_target(x);
        end
        r.letter = x[4:0];
        r.left   = rot_left[4:0];
        r.middle = rot_middle[4:0];
        r.right  = rot_right[4:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cipher_out_t want;
        cipher_out_t got;
        if (!rst_n) begin
            key_rotors    = erc_pkg::ROTOR_ORDER_RST;
            key_rings     = erc_pkg::RING_RST;
            key_plug_low  = erc_pkg::PLUG_LOW_RST;
            key_plug_mid  = erc_pkg::PLUG_MID_RST;
            key_plug_high = erc_pkg::PLUG_HIGH_RST;
            rot_left      = 0;
            rot_middle    = 0;
            rot_right     = 0;
            cipher_expected.delete();
            pending_n <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    erc_pkg::REG_ROTOR_ORDER: key_rotors    = cfg_wdata[8:0];
                    erc_pkg::REG_RING:        key_rings     = cfg_wdata[14:0];
                    erc_pkg::REG_PLUG_LOW:    key_plug_low  = cfg_wdata[44:0];
                    erc_pkg::REG_PLUG_MID:    key_plug_mid  = cfg_wdata[44:0];
                    erc_pkg::REG_PLUG_HIGH:   key_plug_high = cfg_wdata[39:0];
                    default: ;
                endcase
            end

            // retire before queueing so a result cannot match an item accepted in the same cycle
            if (m_tvalid && m_tready) begin
                got = m_tdata[19:0];
                if (cipher_expected.size() == 0) begin
                    $error("result transaction with nothing expected: tdata %h", m_tdata);
                    err_count++;
                end else begin
                    want = cipher_expected.pop_front();
                    if (got.letter !== want.letter) begin
                        $error("letter_out: expected %0d, got %0d", want.letter, got.letter);
                        err_count++;
                    end
                    if (got.left !== want.left) begin
                        $error("now_left: expected %0d, got %0d", want.left, got.left);
                        err_count++;
                    end
                    if (got.middle !== want.middle) begin
                        $error("now_middle: expected %0d, got %0d", want.middle, got.middle);
                        err_count++;
                    end
                    if (got.right !== want.right) begin
                        $error("now_right: expected %0d, got %0d", want.right, got.right);
                        err_count++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                step_and_encipher(s_tuser, s_tdata, want);
                cipher_expected.push_back(want);
            end
            pending_n <= cipher_expected.size();
        end
    end

endmodule

`default_nettype wire

FILE: test/enigma_rotor_cipher_core_test.sv
// Top of the cipher core testbench: clock, reset, stimulus, receiver back-pressure and verdict.
// Depends on erc_pkg, the core itself and enigma_rotor_cipher_check for prediction.
`default_nettype none

module enigma_rotor_cipher_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import erc_pkg::*;

    localparam int ITEMS_PER_KEY = 135;
    localparam int KEY_SETTINGS  = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 48;

    typedef enum int {PLUG_IDENTITY, PLUG_ALL_HIGH, PLUG_ALL_ZERO, PLUG_PAIRS, PLUG_ANY} plug_kind_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;
    logic                  s_tuser = OP_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ROTOR_ORDER;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int tx_idle_pct = 13;
    int rx_idle_pct = 13;
    int n_load = 0;
    int n_enc = 0;
    int n_holds = 0;
    int plug_tgt [26];

    enigma_rotor_cipher_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    enigma_rotor_cipher_check scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: random back-pressure plus a periodic long hold while items are offered
    initial
    begin
        int rx_cycles;
        int next_hold;
        int hold_left;
        rx_cycles = 0;
        next_hold = 300;
        hold_left = 0;
        forever begin
            @(posedge clk);
            rx_cycles++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rst_n && s_tvalid && rx_cycles >= next_hold) begin
                hold_left = HOLD_CYCLES - 1;
                next_hold = rx_cycles + 700;
                n_holds++;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                stall = 0;
            else
                stall++;
        end
        $display("enigma_rotor_cipher_core_test: FAIL");
        $finish;
    end

    function automatic logic [4:0] pick_letter();
        // mostly legal letters, sometimes the out-of-range codes
        return ($urandom_range(99) < 8) ? 5'($urandom_range(31)) : 5'($urandom_range(25));
    endfunction

    task automatic offer_item(input logic op, input logic [4:0] letter, input logic [4:0] l,
                              input logic [4:0] m, input logic [4:0] r);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, r, m, l, letter};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_LOAD)
            n_load++;
        else
            n_enc++;
    endtask

    task automatic offer_random();
        if ($urandom_range(99) < 15)
            offer_item(OP_LOAD, pick_letter(), pick_letter(), pick_letter(), pick_letter());
        else
            offer_item(OP_ENCIPHER, pick_letter(), pick_letter(), pick_letter(), pick_letter());
    endtask

    // hold the sender until every result has been retired
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic build_plugboard(input plug_kind_t kind);
        int perm [26];
        int i;
        int j;
        int tmp;
        int pairs;
        for (i = 0; i < 26; i++) begin
            perm[i] = i;
            case (kind)
                PLUG_ALL_HIGH: plug_tgt[i] = 31;
                PLUG_ALL_ZERO: plug_tgt[i] = 0;
                PLUG_ANY:      plug_tgt[i] = $urandom_range(31);
                default:       plug_tgt[i] = i;
            endcase
        end
        if (kind == PLUG_PAIRS) begin
            for (i = 25; i > 0; i--) begin
                j = $urandom_range(i);
                tmp = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            pairs = $urandom_range(13);
            for (i = 0; i < pairs; i++) begin
                plug_tgt[perm[2*i]]   = perm[2*i+1];
                plug_tgt[perm[2*i+1]] = perm[2*i];
            end
        end
    endtask

    function automatic logic [8:0] pick_rotor_set();
        int a;
        int b;
        int c;
        a = $urandom_range(5, 1);
        do b = $urandom_range(5, 1); while (b == a);
        do c = $urandom_range(5, 1); while (c == a || c == b);
        return {3'(a), 3'(b), 3'(c)};
    endfunction

    task automatic load_key(input logic [8:0] rotors, input logic [14:0] rings,
                            input plug_kind_t kind);
        logic [129:0] board;
        int k;
        build_plugboard(kind);
        for (k = 0; k < 26; k++)
            board[5*k +: 5] = 5'(plug_tgt[k]);
        write_reg(REG_ROTOR_ORDER, CFG_DATA_W'(rotors));
        write_reg(REG_RING, CFG_DATA_W'(rings));
        write_reg(REG_PLUG_LOW, board[44:0]);
        write_reg(REG_PLUG_MID, board[89:45]);
        write_reg(REG_PLUG_HIGH, CFG_DATA_W'(board[129:90]));
        cfg_we <= 1'b0;
    endtask

    task automatic apply_key(input int phase);
        case (phase)
            0: load_key(9'd0, 15'd0, PLUG_IDENTITY);
            1: load_key(9'h1FF, 15'h7FFF, PLUG_ALL_HIGH);
            2: load_key({3'd5, 3'd4, 3'd3}, {5'd25, 5'd25, 5'd25}, PLUG_ALL_ZERO);
            6: load_key(9'($urandom_range(511)), 15'($urandom_range(32767)), PLUG_ANY);
            7: load_key(pick_rotor_set(), 15'($urandom_range(32767)), PLUG_PAIRS);
            default: load_key(pick_rotor_set(),
                              {5'($urandom_range(25)), 5'($urandom_range(25)),
                               5'($urandom_range(25))}, PLUG_PAIRS);
        endcase
    endtask

    initial
    begin
        int phase;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key and reset positions, then letter extremes and saturation
        offer_item(OP_ENCIPHER, 5'd0, 5'd0, 5'd0, 5'd0);
        offer_item(OP_ENCIPHER, 5'd25, 5'd0, 5'd0, 5'd0);
        offer_item(OP_ENCIPHER, 5'd31, 5'd31, 5'd31, 5'd31);
        offer_item(OP_LOAD, 5'd31, 5'd31, 5'd31, 5'd31);
        offer_item(OP_ENCIPHER, 5'd7, 5'd0, 5'd0, 5'd0);
        // middle rotor double step across the right rotor notch
        offer_item(OP_LOAD, 5'd0, 5'd0, 5'd3, 5'd20);
        repeat (4) offer_item(OP_ENCIPHER, 5'd0, 5'd0, 5'd0, 5'd0);
        // middle and right both at their notches at once
        offer_item(OP_LOAD, 5'd0, 5'd25, 5'd4, 5'd21);
        offer_item(OP_ENCIPHER, 5'd12, 5'd0, 5'd0, 5'd0);
        offer_item(OP_LOAD, 5'd0, 5'd25, 5'd25, 5'd25);
        offer_item(OP_LOAD, 5'd0, 5'd0, 5'd0, 5'd0);
        offer_item(OP_ENCIPHER, 5'd1, 5'd0, 5'd0, 5'd0);
        offer_item(OP_ENCIPHER, 5'd2, 5'd0, 5'd0, 5'd0);
        offer_item(OP_ENCIPHER, 5'd4, 5'd0, 5'd0, 5'd0);
        offer_item(OP_ENCIPHER, 5'd8, 5'd0, 5'd0, 5'd0);
        offer_item(OP_ENCIPHER, 5'd16, 5'd0, 5'd0, 5'd0);
        offer_item(OP_LOAD, 5'd0, 5'd26, 5'd27, 5'd30);
        offer_item(OP_ENCIPHER, 5'd25, 5'd0, 5'd0, 5'd0);

        for (phase = 0; phase < KEY_SETTINGS; phase++) begin
            drain();
            apply_key(phase);
            // last key runs with no random idling on either side
            tx_idle_pct = (phase == KEY_SETTINGS - 1) ? 0 : 13;
            rx_idle_pct = tx_idle_pct;
            offer_item(OP_LOAD, pick_letter(), 5'($urandom_range(25)),
                       5'($urandom_range(25)), 5'($urandom_range(25)));
            for (n = 1; n < ITEMS_PER_KEY; n++)
                offer_random();
        end

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d load and %0d encipher transactions over %0d key settings",
                 n_load, n_enc, KEY_SETTINGS + 1);
        $display("receiver held off %0d times for %0d cycles each", n_holds, HOLD_CYCLES);
        if (mismatches == 0)
            $display("enigma_rotor_cipher_core_test: PASS");
        else
            $display("enigma_rotor_cipher_core_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
